FILE: hw/rtl/mexp_pkg.sv
// ----------------------------------------------------------------------------
// mexp_pkg
// shared constants for the modular exponentiation block
// ----------------------------------------------------------------------------
package mexp_pkg;

    // width of every field on the request and response channels
    localparam int FIELD_BITS    = 64;

    // default datapath width, 8 to 64
    localparam int DEF_WORD_BITS = 64;

endpackage

FILE: hw/rtl/mexp_ifs.sv
// ----------------------------------------------------------------------------
// mexp request and response interfaces
// valid/ready channels carrying the operands and the result
// ----------------------------------------------------------------------------
interface mexp_req_if import mexp_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [FIELD_BITS-1:0] base_value;
    logic [FIELD_BITS-1:0] exponent;
    logic [FIELD_BITS-1:0] modulus;

    modport source (output valid, output base_value, output exponent, output modulus,
                    input ready);
    modport sink   (input valid, input base_value, input exponent, input modulus,
                    output ready);
endinterface

interface mexp_rsp_if import mexp_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [FIELD_BITS-1:0] power_result;
    logic                  zero_modulus_error;

    modport source (output valid, output power_result, output zero_modulus_error,
                    input ready);
    modport sink   (input valid, input power_result, input zero_modulus_error,
                    output ready);
endinterface

FILE: hw/rtl/mexp_modadd.sv
// ----------------------------------------------------------------------------
// mexp_modadd
// modular adder: (a + b + cin) mod m for a, b below m
// ----------------------------------------------------------------------------
module mexp_modadd import mexp_pkg::*; #(
    parameter int WORD_BITS = DEF_WORD_BITS
) (
    input  logic [WORD_BITS-1:0] i_a,
    input  logic [WORD_BITS-1:0] i_b,
    input  logic [WORD_BITS-1:0] i_m,
    input  logic                 i_cin,
    output logic [WORD_BITS-1:0] o_sum
);

    // one extra bit keeps the carry for moduli in the top half of the range
    logic [WORD_BITS:0] w_sum;
    logic [WORD_BITS:0] w_diff;

    assign w_sum  = {1'b0, i_a} + {1'b0, i_b} + {{WORD_BITS{1'b0}}, i_cin};
    assign w_diff = w_sum - {1'b0, i_m};
    // sum is below 2m, so one subtract is enough
    assign o_sum  = (w_sum >= {1'b0, i_m}) ? w_diff[WORD_BITS-1:0]
                                           : w_sum[WORD_BITS-1:0];

endmodule

FILE: hw/rtl/modular_exponentiation_unit.sv
// ----------------------------------------------------------------------------
// modular_exponentiation_unit
// base ^ exponent mod modulus by right-to-left square-and-multiply
// ----------------------------------------------------------------------------
// usage
//   i_req carries base_value, exponent and modulus; a request is taken when
//   valid and ready are both high. ready is high only while the sequencer
//   is idle, so one request is worked on at a time.
//   o_rsp carries power_result and zero_modulus_error, one per request, from
//   an output register; a new request may be taken while it still waits.
//   only the low WORD_BITS bits of each operand are used.
// operation
//   a zero modulus goes straight to the result. otherwise the base is first
//   reduced mod the modulus, then each exponent bit up to the top set one
//   takes an optional multiply of the result by the base and a square of
//   the base, both done by the modular add/double unit, which retires one
//   multiplier bit per cycle.
// reset
//   synchronous, active low; returns to idle and drops the response valid.
// stall
//   a finished result waits in the sequencer until the output register is
//   free; the next request is taken only after that.
// ----------------------------------------------------------------------------
module modular_exponentiation_unit import mexp_pkg::*; #(
    parameter int WORD_BITS = DEF_WORD_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mexp_req_if.sink    i_req,
    mexp_rsp_if.source  o_rsp
);

    localparam int CNT_W = $clog2(WORD_BITS);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,   // waiting for a request
        S_RED  = 6'b000010,   // base mod modulus, one base bit per cycle
        S_CHK  = 6'b000100,   // pick the next multiply from the exponent
        S_MUL  = 6'b001000,   // result times base
        S_SQR  = 6'b010000,   // base squared
        S_DONE = 6'b100000    // result ready for the output register
    } t_state;

    t_state                 r_state, n_state;
    logic [WORD_BITS-1:0]   r_m,   n_m;      // modulus
    logic [WORD_BITS-1:0]   r_e,   n_e;      // remaining exponent bits
    logic [WORD_BITS-1:0]   r_b,   n_b;      // running base power
    logic [WORD_BITS-1:0]   r_r,   n_r;      // running result
    logic [WORD_BITS-1:0]   r_x,   n_x;      // base bits still to reduce
    logic [WORD_BITS-1:0]   r_acc, n_acc;    // product accumulator
    logic [WORD_BITS-1:0]   r_dbl, n_dbl;    // doubled multiplicand / remainder
    logic [WORD_BITS-1:0]   r_y,   n_y;      // remaining multiplier bits
    logic [CNT_W-1:0]       r_cnt, n_cnt;    // reduction step counter
    logic                   r_err, n_err;

    // output register
    logic                   r_rsp_valid, n_rsp_valid;
    logic [WORD_BITS-1:0]   r_res,       n_res;
    logic                   r_rsp_err,   n_rsp_err;

    logic [WORD_BITS-1:0]   w_add_sum;   // acc + dbl mod m
    logic [WORD_BITS-1:0]   w_dbl_sum;   // 2 * dbl (+ base bit) mod m
    logic                   w_dbl_cin;
    logic                   w_req_take;
    logic [WORD_BITS-1:0]   w_in_m;

    // shared add/double unit: the accumulate lane and the doubling lane
    assign w_dbl_cin = (r_state == S_RED) ? r_x[WORD_BITS-1] : 1'b0;

    mexp_modadd #(.WORD_BITS(WORD_BITS)) u_add_lane (
        .i_a   (r_acc),
        .i_b   (r_dbl),
        .i_m   (r_m),
        .i_cin (1'b0),
        .o_sum (w_add_sum)
    );

    mexp_modadd #(.WORD_BITS(WORD_BITS)) u_dbl_lane (
        .i_a   (r_dbl),
        .i_b   (r_dbl),
        .i_m   (r_m),
        .i_cin (w_dbl_cin),
        .o_sum (w_dbl_sum)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign w_req_take  = i_req.valid && (r_state == S_IDLE);
    assign w_in_m      = i_req.modulus[WORD_BITS-1:0];

    assign o_rsp.valid              = r_rsp_valid;
    assign o_rsp.power_result       = FIELD_BITS'(r_res);
    assign o_rsp.zero_modulus_error = r_rsp_err;

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_m         = r_m;
        n_e         = r_e;
        n_b         = r_b;
        n_r         = r_r;
        n_x         = r_x;
        n_acc       = r_acc;
        n_dbl       = r_dbl;
        n_y         = r_y;
        n_cnt       = r_cnt;
        n_err       = r_err;
        n_rsp_valid = r_rsp_valid;
        n_res       = r_res;
        n_rsp_err   = r_rsp_err;

        // response taken downstream
        if (r_rsp_valid && o_rsp.ready) begin
            n_rsp_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_req_take) begin
                    n_m   = w_in_m;
                    n_e   = i_req.exponent[WORD_BITS-1:0];
                    n_x   = i_req.base_value[WORD_BITS-1:0];
                    n_dbl = '0;
                    n_cnt = CNT_W'(WORD_BITS - 1);
                    if (w_in_m == '0) begin
                        // zero modulus: flag it, result zero
                        n_r     = '0;
                        n_err   = 1'b1;
                        n_state = S_DONE;
                    end else begin
                        // 1 mod m is zero only for a unit modulus
                        n_r     = (w_in_m == WORD_BITS'(1)) ? '0 : WORD_BITS'(1);
                        n_err   = 1'b0;
                        n_state = S_RED;
                    end
                end
            end
            S_RED: begin
                // restoring remainder, base bits shifted in from the top
                n_dbl = w_dbl_sum;
                n_x   = {r_x[WORD_BITS-2:0], 1'b0};
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    n_b     = w_dbl_sum;
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                n_acc = '0;
                n_y   = r_b;
                if (r_e == '0) begin
                    n_state = S_DONE;
                end else if (r_e[0]) begin
                    n_dbl   = r_r;
                    n_state = S_MUL;
                end else begin
                    n_dbl   = r_b;
                    n_state = S_SQR;
                end
            end
            S_MUL: begin
                if (r_y == '0) begin
                    // product done, square the base next
                    n_r     = r_acc;
                    n_acc   = '0;
                    n_dbl   = r_b;
                    n_y     = r_b;
                    n_state = S_SQR;
                end else begin
                    if (r_y[0]) begin
                        n_acc = w_add_sum;
                    end
                    n_dbl = w_dbl_sum;
                    n_y   = r_y >> 1;
                end
            end
            S_SQR: begin
                if (r_y == '0) begin
                    n_b     = r_acc;
                    n_e     = r_e >> 1;
                    n_state = S_CHK;
                end else begin
                    if (r_y[0]) begin
                        n_acc = w_add_sum;
                    end
                    n_dbl = w_dbl_sum;
                    n_y   = r_y >> 1;
                end
            end
            S_DONE: begin
                // hand over once the output register is free
                if (!r_rsp_valid || o_rsp.ready) begin
                    n_rsp_valid = 1'b1;
                    n_res       = r_r;
                    n_rsp_err   = r_err;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_m       <= n_m;
        r_e       <= n_e;
        r_b       <= n_b;
        r_r       <= n_r;
        r_x       <= n_x;
        r_acc     <= n_acc;
        r_dbl     <= n_dbl;
        r_y       <= n_y;
        r_cnt     <= n_cnt;
        r_err     <= n_err;
        r_res     <= n_res;
        r_rsp_err <= n_rsp_err;
    end

endmodule

FILE: bench/modular_exponentiation_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// modular_exponentiation_unit_test
// self-checking bench for base ^ exponent mod modulus
// directed corner requests, then random ones drawn mostly with short
// exponents; each response is checked against a local square-and-multiply
// predictor, with random idling on both channels
// ----------------------------------------------------------------------------
module modular_exponentiation_unit_test;
    import mexp_pkg::*;

    localparam int  WORD_BITS    = DEF_WORD_BITS;
    localparam int  TAIL_ITEMS   = 12;   // last requests sent with no idling
    localparam int  SETTLE_WAIT  = 200;  // cycles to watch for stray responses
    localparam int  RANDOM_ITEMS = 84;
    localparam int  MAX_REPORTS  = 10;

    typedef logic [FIELD_BITS-1:0] t_word;

    localparam t_word WORD_MASK = {FIELD_BITS{1'b1}} >> (FIELD_BITS - WORD_BITS);
    localparam t_word ALL_ONES  = {FIELD_BITS{1'b1}};
    localparam t_word TOP_BIT   = t_word'(1) << (FIELD_BITS - 1);

    // one pending request, optionally held back until all responses are in
    typedef struct {
        t_word base_value;
        t_word exponent;
        t_word modulus;
        bit    wait_for_drain;
    } t_power_req;

    // one expected response
    typedef struct {
        t_word power_result;
        logic  zero_modulus_error;
    } t_power_resp;

    logic i_clk;
    logic i_rst_n;

    mexp_req_if req_bus ();
    mexp_rsp_if rsp_bus ();

    modular_exponentiation_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus.sink),
        .o_rsp   (rsp_bus.source)
    );

    t_power_req  pending_requests[$];
    t_power_resp expected_powers[$];

    t_power_req  next_req;
    t_power_resp oldest_power;
    logic        req_taken;
    int          send_gap;
    int          stall_left;
    int          error_count = 0;

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // (x + y) mod m for x, y < m; the sum keeps its carry bit so that moduli
    // above half the word range still reduce correctly
    function automatic t_word add_mod_word(t_word x, t_word y, t_word m);
        logic [FIELD_BITS:0] sum;
        sum = {1'b0, x} + {1'b0, y};
        if (sum >= {1'b0, m}) begin
            sum = sum - {1'b0, m};
        end
        return sum[FIELD_BITS-1:0];
    endfunction

    // (x * y) mod m by shift-and-add, one multiplier bit per pass
    function automatic t_word shift_add_mulmod(t_word x, t_word y, t_word m);
        t_word acc;
        t_word dbl;
        acc = '0;
        dbl = x % m;
        while (y != 0) begin
            if (y[0]) begin
                acc = add_mod_word(acc, dbl, m);
            end
            dbl = add_mod_word(dbl, dbl, m);
            y   = y >> 1;
        end
        return acc;
    endfunction

    // right-to-left square-and-multiply on the low WORD_BITS of each operand
    function automatic t_power_resp predict_power(t_word b_in, t_word e_in, t_word m_in);
        t_power_resp rsp;
        t_word       b;
        t_word       e;
        t_word       m;
        t_word       r;
        b = b_in & WORD_MASK;
        e = e_in & WORD_MASK;
        m = m_in & WORD_MASK;
        rsp.power_result       = '0;
        rsp.zero_modulus_error = 1'b0;
        if (m == 0) begin
            // zero modulus: flagged, result forced to zero
            rsp.zero_modulus_error = 1'b1;
            return rsp;
        end
        r = t_word'(1) % m;   // unit modulus gives zero here already
        b = b % m;
        while (e != 0) begin
            if (e[0]) begin
                r = shift_add_mulmod(r, b, m);
            end
            e = e >> 1;
            b = shift_add_mulmod(b, b, m);
        end
        rsp.power_result = r & WORD_MASK;
        return rsp;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    function automatic t_word random_word();
        return {$urandom, $urandom};
    endfunction

    // random value of 1 to max_bits significant bits
    function automatic t_word random_narrow(int max_bits);
        return random_word() >> (FIELD_BITS - $urandom_range(1, max_bits));
    endfunction

    function automatic void add_request(t_word b, t_word e, t_word m, bit drain);
        t_power_req item;
        item.base_value     = b;
        item.exponent       = e;
        item.modulus        = m;
        item.wait_for_drain = drain;
        pending_requests.push_back(item);
    endfunction

    // ------------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------------
    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // request driver: changes on the falling edge, fed from pending_requests
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_bus.valid <= 1'b0;
            send_gap      <= 0;
        end else if (req_bus.valid && !req_taken) begin
            // request still on offer, hold it steady
        end else if (send_gap != 0) begin
            send_gap      <= send_gap - 1;
            req_bus.valid <= 1'b0;
        end else if (pending_requests.size() != 0 &&
                     !(pending_requests[0].wait_for_drain && expected_powers.size() != 0)) begin
            next_req = pending_requests.pop_front();
            req_bus.base_value <= next_req.base_value;
            req_bus.exponent   <= next_req.exponent;
            req_bus.modulus    <= next_req.modulus;
            req_bus.valid      <= 1'b1;
            // occasional burst of idle cycles after this request, none in the tail
            if (pending_requests.size() >= TAIL_ITEMS && $urandom_range(0, 4) == 0) begin
                send_gap <= $urandom_range(1, 6);
            end
        end else begin
            // nothing to send, or holding off until every response is back
            req_bus.valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // response sink: random stall bursts, steady ready in the tail
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rsp_bus.ready <= 1'b0;
            stall_left    <= 0;
        end else if (stall_left != 0) begin
            stall_left    <= stall_left - 1;
            rsp_bus.ready <= 1'b0;
        end else if (pending_requests.size() >= TAIL_ITEMS && $urandom_range(0, 5) == 0) begin
            stall_left    <= $urandom_range(0, 5);
            rsp_bus.ready <= 1'b0;
        end else begin
            rsp_bus.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // monitor: sampled on the rising edge; the response is checked before the
    // new request's prediction is queued so the fifo order stays right
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_taken <= 1'b0;
        end else begin
            if (rsp_bus.valid && rsp_bus.ready) begin
                if (expected_powers.size() == 0) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS) begin
                        $display("%t: response with nothing expected: power %h error %b",
                                 $realtime, rsp_bus.power_result, rsp_bus.zero_modulus_error);
                    end
                end else begin
                    oldest_power = expected_powers.pop_front();
                    if (rsp_bus.power_result !== oldest_power.power_result ||
                        rsp_bus.zero_modulus_error !== oldest_power.zero_modulus_error) begin
                        error_count++;
                        if (error_count <= MAX_REPORTS) begin
                            $display("%t: mismatch: power %h error %b, expected power %h error %b",
                                     $realtime, rsp_bus.power_result,
                                     rsp_bus.zero_modulus_error,
                                     oldest_power.power_result,
                                     oldest_power.zero_modulus_error);
                        end
                    end
                end
            end
            if (req_bus.valid && req_bus.ready) begin
                expected_powers.push_back(predict_power(req_bus.base_value,
                                                        req_bus.exponent,
                                                        req_bus.modulus));
            end
            req_taken <= req_bus.valid && req_bus.ready;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        t_word b;
        t_word e;
        t_word m;
        int    pick;

        i_rst_n = 1'b0;

        // directed corners
        add_request('0, '0, '0, 1'b0);                           // zero modulus, all zero
        add_request(ALL_ONES, ALL_ONES, '0, 1'b0);               // zero modulus, all ones
        add_request(64'd5, 64'd3, 64'd1, 1'b0);                  // unit modulus
        add_request(64'd7, '0, 64'd13, 1'b0);                    // zero exponent
        add_request('0, '0, 64'd1, 1'b0);                        // zero exponent, unit modulus
        add_request('0, 64'd5, 64'd97, 1'b0);                    // zero base
        add_request(64'd3, 64'd10, 64'd1000, 1'b0);              // small sanity case
        add_request(ALL_ONES, ALL_ONES, ALL_ONES, 1'b0);         // every field at its top
        add_request(ALL_ONES - 1, 64'd2, ALL_ONES, 1'b0);        // sum carries out of word
        add_request(64'd2, TOP_BIT, TOP_BIT | 64'd1, 1'b0);      // long exponent, wide modulus
        add_request(ALL_ONES, 64'd1, TOP_BIT | 64'd1, 1'b0);     // base reduced by wide modulus
        add_request(64'd123456789, 64'd65537, 64'hFFFF_FFFF_FFFF_FFC5, 1'b0);
        add_request(64'd1000003, 64'd3, 64'd1000003, 1'b0);      // base equal to modulus
        add_request(random_word(), ALL_ONES, TOP_BIT, 1'b0);     // power of two modulus
        add_request(64'd12345, 64'd17, 64'd2, 1'b0);             // modulus of two
        add_request(ALL_ONES, 64'd3, 64'd255, 1'b0);             // high base bits above modulus

        // random requests, mostly short exponents to keep the run brisk
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 4)       m = '0;
            else if (pick < 8)  m = 64'd1;
            else if (pick < 30) m = TOP_BIT | random_word();
            else if (pick < 45) m = random_narrow(20);
            else                m = random_word();

            pick = $urandom_range(0, 99);
            if (pick < 4)       b = '0;
            else if (pick < 8)  b = ALL_ONES;
            else if (pick < 25) b = random_narrow(16);
            else                b = random_word();

            pick = $urandom_range(0, 99);
            if (pick < 4)       e = '0;
            else if (pick < 12) e = random_word();
            else                e = random_narrow(12);

            // first random request waits for a full drain, a few others too
            add_request(b, e, m, (i == 0) || ($urandom_range(0, 19) == 0));
        end

        // reset held, then released on a falling edge
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // wait for every request to go out and every response to come back
        while (pending_requests.size() != 0 || req_bus.valid || expected_powers.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_WAIT) @(posedge i_clk);

        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // watchdog, several times the slowest legal run
    initial begin
        #50_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
